@@ src/jwdm_pkg.sv @@
package jwdm_pkg;

  localparam int AXIS_W   = 8;
  localparam int BTN_W    = 6;
  localparam int RPM_W    = 13;
  localparam int DB_W     = 8;
  localparam int TGT_W    = 21;
  localparam int CNT_W    = 2;
  localparam int CFG_W    = RPM_W;
  localparam int WHEELS   = 4;

  localparam logic [AXIS_W-1:0] CENTRE        = AXIS_W'(128);
  localparam logic [RPM_W-1:0]  RPM_RESET     = RPM_W'(4000);
  localparam logic [DB_W-1:0]   DB_RESET      = DB_W'(50);
  localparam logic [CNT_W-1:0]  CNT_MAX       = CNT_W'(3);
  localparam logic [CNT_W-1:0]  CNT_STABLE    = CNT_W'(2);
  localparam int                STOP_BTN      = 0;

  // wheel direction, two's complement -1/0/+1
  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_t;

  typedef enum logic [0:0] {
    CFG_FULL_SPEED = 1'b0,
    CFG_DEAD_BAND  = 1'b1
  } cfg_idx_t;

  typedef logic signed [TGT_W-1:0] target_t;

endpackage

@@ src/joystick_wheel_drive_mapper.sv @@
// Maps one gamepad word per cycle onto four wheel directions and speed targets.
// Every accepted word yields exactly one result word: the four current targets
// (1/128 rpm, two's complement) and a flag telling whether this word wrote them.
// Throughput is one word per cycle while out_stall is low; a word passes the
// input register, then the classify / 13x8 multiply / debounce logic into
// the result register, which also holds the wheel state. A stalled result holds
// the input register, and the input side stalls only when that register is full
// and cannot move on. Config (full_speed_rpm, dead_band) is written through a
// plain write port and takes effect on the next word that reaches the logic.
module joystick_wheel_drive_mapper (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write port
  input  logic                                 cfg_we,
  input  jwdm_pkg::cfg_idx_t                   cfg_index,
  input  logic [jwdm_pkg::CFG_W-1:0]           cfg_data,
  // gamepad words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [jwdm_pkg::AXIS_W-1:0]          in_left_y,
  input  logic [jwdm_pkg::AXIS_W-1:0]          in_left_x,
  input  logic [jwdm_pkg::AXIS_W-1:0]          in_right_y,
  input  logic [jwdm_pkg::BTN_W-1:0]           in_buttons,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [jwdm_pkg::TGT_W-1:0]    out_wheel_one_target,
  output logic signed [jwdm_pkg::TGT_W-1:0]    out_wheel_two_target,
  output logic signed [jwdm_pkg::TGT_W-1:0]    out_wheel_three_target,
  output logic signed [jwdm_pkg::TGT_W-1:0]    out_wheel_four_target,
  output logic                                 out_targets_changed
);
  import jwdm_pkg::*;

  // config registers
  logic [RPM_W-1:0]  full_speed_r;
  logic [DB_W-1:0]   dead_band_r;

  // input register
  logic              s1_valid_r;
  logic [AXIS_W-1:0] s1_left_y_r;
  logic [AXIS_W-1:0] s1_left_x_r;
  logic [AXIS_W-1:0] s1_right_y_r;
  logic [BTN_W-1:0]  s1_buttons_r;

  // wheel state; the target registers double as the result payload
  dir_t              wheel_dir_r    [WHEELS];
  dir_t              wheel_dir_nxt  [WHEELS];
  target_t           wheel_tgt_r    [WHEELS];
  target_t           wheel_tgt_nxt  [WHEELS];
  logic [BTN_W-1:0]  last_sample_r;
  logic [BTN_W-1:0]  last_sample_nxt;
  logic [CNT_W-1:0]  run_cnt_r;
  logic [CNT_W-1:0]  run_cnt_nxt;
  logic [BTN_W-1:0]  prev_stable_r;
  logic [BTN_W-1:0]  prev_stable_nxt;

  // result register control
  logic              out_valid_r;
  logic              out_changed_r;
  logic              out_changed_nxt;

  logic              s1_adv;
  logic              in_acc;

  // datapath intermediates
  logic [AXIS_W-1:0]   dx;
  logic [AXIS_W-1:0]   dy;
  logic                in_x;
  logic                in_y;
  logic                speed_upd;
  logic [AXIS_W-1:0]   defl;
  logic [TGT_W-1:0]    mag;
  target_t             mag_pos;
  target_t             mag_neg;
  logic                stable;
  logic [BTN_W-1:0]    rise;
  logic                stop_edge;

  // word moves out of the input register when the result side can take it
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // distance of each axis from centre
  assign dx   = (s1_left_x_r >= CENTRE) ? AXIS_W'(s1_left_x_r - CENTRE)
                                         : AXIS_W'(CENTRE - s1_left_x_r);
  assign dy   = (s1_left_y_r >= CENTRE) ? AXIS_W'(s1_left_y_r - CENTRE)
                                         : AXIS_W'(CENTRE - s1_left_y_r);
  assign in_x = dx < dead_band_r;
  assign in_y = dy < dead_band_r;

  // direction rules, first match wins, otherwise hold
  always_comb begin
    wheel_dir_nxt = wheel_dir_r;
    priority if (s1_left_y_r > CENTRE && in_x) begin
      wheel_dir_nxt = '{DIR_NEG, DIR_NEG, DIR_NEG, DIR_NEG};
    end else if (s1_left_y_r < CENTRE && in_x) begin
      wheel_dir_nxt = '{DIR_POS, DIR_POS, DIR_POS, DIR_POS};
    end else if (in_x) begin
      wheel_dir_nxt = '{DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP};
    end else if (s1_left_x_r < CENTRE && in_y) begin
      wheel_dir_nxt = '{DIR_NEG, DIR_POS, DIR_NEG, DIR_POS};
    end else if (s1_left_x_r > CENTRE && in_y) begin
      wheel_dir_nxt = '{DIR_POS, DIR_NEG, DIR_POS, DIR_NEG};
    end else if (in_y) begin
      wheel_dir_nxt = '{DIR_STOP, DIR_STOP, DIR_STOP, DIR_STOP};
    end else begin
      wheel_dir_nxt = wheel_dir_r;
    end
  end

  // speed magnitude: full speed times right stick deflection (0..128)
  assign speed_upd = s1_right_y_r <= CENTRE;
  assign defl      = AXIS_W'(CENTRE - s1_right_y_r);
  assign mag       = TGT_W'(full_speed_r) * TGT_W'(defl);
  assign mag_pos   = target_t'(mag);
  assign mag_neg   = target_t'(~mag + TGT_W'(1));

  // button debounce
  always_comb begin
    last_sample_nxt = last_sample_r;
    if (s1_buttons_r == last_sample_r) begin
      run_cnt_nxt = (run_cnt_r < CNT_MAX) ? CNT_W'(run_cnt_r + CNT_W'(1)) : run_cnt_r;
    end else begin
      run_cnt_nxt     = '0;
      last_sample_nxt = s1_buttons_r;
    end
  end

  assign stable          = run_cnt_nxt >= CNT_STABLE;
  assign rise            = s1_buttons_r & ~prev_stable_r;
  assign stop_edge       = stable && rise[STOP_BTN];
  assign prev_stable_nxt = stable ? s1_buttons_r : prev_stable_r;

  // targets: speed update first, stop edge overrides
  always_comb begin
    wheel_tgt_nxt = wheel_tgt_r;
    if (speed_upd) begin
      for (int w = 0; w < WHEELS; w++) begin
        unique case (wheel_dir_nxt[w])
          DIR_POS: wheel_tgt_nxt[w] = mag_pos;
          DIR_NEG: wheel_tgt_nxt[w] = mag_neg;
          default: wheel_tgt_nxt[w] = '0;
        endcase
      end
    end
    if (stop_edge) begin
      for (int w = 0; w < WHEELS; w++) begin
        wheel_tgt_nxt[w] = '0;
      end
    end
  end

  assign out_changed_nxt = speed_upd || stop_edge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_speed_r  <= RPM_RESET;
      dead_band_r   <= DB_RESET;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_sample_r <= '0;
      run_cnt_r     <= '0;
      prev_stable_r <= '0;
      for (int w = 0; w < WHEELS; w++) begin
        wheel_dir_r[w] <= DIR_STOP;
        wheel_tgt_r[w] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FULL_SPEED: full_speed_r <= cfg_data[RPM_W-1:0];
          CFG_DEAD_BAND:  dead_band_r  <= cfg_data[DB_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        s1_valid_r   <= 1'b1;
        s1_left_y_r  <= in_left_y;
        s1_left_x_r  <= in_left_x;
        s1_right_y_r <= in_right_y;
        s1_buttons_r <= in_buttons;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r   <= 1'b1;
        out_changed_r <= out_changed_nxt;
        wheel_dir_r   <= wheel_dir_nxt;
        wheel_tgt_r   <= wheel_tgt_nxt;
        last_sample_r <= last_sample_nxt;
        run_cnt_r     <= run_cnt_nxt;
        prev_stable_r <= prev_stable_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_targets_changed    = out_changed_r;
  assign out_wheel_one_target   = wheel_tgt_r[0];
  assign out_wheel_two_target   = wheel_tgt_r[1];
  assign out_wheel_three_target = wheel_tgt_r[2];
  assign out_wheel_four_target  = wheel_tgt_r[3];

  // diagonal wheels always share direction and target
  a_diag_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    wheel_dir_r[0] == wheel_dir_r[2] && wheel_dir_r[1] == wheel_dir_r[3] &&
    wheel_tgt_r[0] == wheel_tgt_r[2] && wheel_tgt_r[1] == wheel_tgt_r[3])
    else $error("diagonal wheels disagree");

  // a speed update always flags the result
  a_speed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && speed_upd |=> out_valid_r && out_changed_r)
    else $error("speed update not flagged");

  // stop edge leaves all targets at zero
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && stop_edge |=> wheel_tgt_r[0] == '0 && wheel_tgt_r[1] == '0 &&
                            wheel_tgt_r[2] == '0 && wheel_tgt_r[3] == '0)
    else $error("stop edge did not clear targets");

  // wheel state only moves together with a new result word
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(wheel_tgt_r[0]) && $stable(wheel_tgt_r[1]) &&
                $stable(run_cnt_r) && $stable(prev_stable_r))
    else $error("state changed without a word");

endmodule
